// ===== rtl/core/vrl_pkg.sv =====
package vrl_pkg;

   localparam int COORD_BITS = 16;
   localparam int LEN_BITS   = 15;
   localparam int OUT_BITS   = 16;
   localparam int SUM_BITS   = 2 * COORD_BITS;
   localparam int PROD_BITS  = COORD_BITS + LEN_BITS;
   localparam int NUM_BITS   = 2 * PROD_BITS;
   localparam int QUO_BITS   = 2 * LEN_BITS;
   localparam int FRONT_LAT  = 3;
   localparam int SIDE_LAT   = QUO_BITS + LEN_BITS;
   localparam int PIPE_LAT   = FRONT_LAT + SIDE_LAT + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic        [LEN_BITS-1:0]   target_length;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] out_x;
      logic signed [OUT_BITS-1:0] out_y;
      logic                       zero_vector;
   } rsp_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
   } side_type;

endpackage

// ===== rtl/core/vector_rescale_to_length.sv =====
// Rescales a signed 2D direction to a requested length:
// out = dir * target_length / |dir|, each component truncated toward zero.
// Input channel req_*: one beat per vector (dir_x, dir_y, target_length).
// Result channel rsp_*: one beat per input beat, in order
// (out_x, out_y, zero_vector). A zero direction gives zero_vector = 1
// and zero components.
// The pipeline is made of 3 front stages (magnitudes, products, squares),
// a 30-stage restoring divider (one quotient bit per stage), a 15-stage
// square root (one root bit per stage) and the output register.
// Throughput: one vector per cycle while no stalled result is pending.
// Reset clears the valid bits only; the data registers are not reset.
// When rsp_stall is high with a result pending, the whole pipeline holds
// and req_stall rises; nothing is lost or repeated.
module vector_rescale_to_length (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vrl_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vrl_pkg::rsp_type  rsp_payload
);
   import vrl_pkg::*;

   logic                valid_ff [0:PIPE_LAT-1];
   side_type            side_ff  [0:SIDE_LAT-1];
   rsp_type             rsp_ff, rsp_in;
   logic                adv;
   logic [SUM_BITS-1:0] sum_sq;
   logic [NUM_BITS-1:0] num_x, num_y;
   side_type            side_c;
   logic [QUO_BITS-1:0] quo_x, quo_y;
   logic [LEN_BITS-1:0] root_x, root_y;
   side_type            side_out;

   assign adv       = !(valid_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;

   vrl_front u_front (
      .clock  (clock),
      .adv    (adv),
      .req    (req_payload),
      .sum_sq (sum_sq),
      .num_x  (num_x),
      .num_y  (num_y),
      .side   (side_c)
   );

   vrl_div u_div_x (.clock(clock), .adv(adv), .num(num_x), .den(sum_sq), .quo(quo_x));
   vrl_div u_div_y (.clock(clock), .adv(adv), .num(num_y), .den(sum_sq), .quo(quo_y));

   vrl_sqrt u_sqrt_x (.clock(clock), .adv(adv), .rad(quo_x), .root(root_x));
   vrl_sqrt u_sqrt_y (.clock(clock), .adv(adv), .rad(quo_y), .root(root_y));

   assign side_out = side_ff[SIDE_LAT-1];

   always_comb begin
      rsp_in.zero_vector = side_out.zero;
      if (side_out.zero) begin
         rsp_in.out_x = '0;
         rsp_in.out_y = '0;
      end else begin
         rsp_in.out_x = side_out.neg_x ? -OUT_BITS'(root_x) : OUT_BITS'(root_x);
         rsp_in.out_y = side_out.neg_y ? -OUT_BITS'(root_y) : OUT_BITS'(root_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_c;
         for (int i = 1; i < SIDE_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff[PIPE_LAT-1];
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/vrl_front.sv =====
module vrl_front (
   input  logic                                 clock,
   input  logic                                 adv,
   input  vrl_pkg::req_type                     req,
   output logic [vrl_pkg::SUM_BITS-1:0]         sum_sq,
   output logic [vrl_pkg::NUM_BITS-1:0]         num_x,
   output logic [vrl_pkg::NUM_BITS-1:0]         num_y,
   output vrl_pkg::side_type                    side
);
   import vrl_pkg::*;

   logic [COORD_BITS-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [LEN_BITS-1:0]   len_ff;
   side_type              side_a_ff, side_b_ff, side_c_ff, side_in;
   logic [SUM_BITS-1:0]   sqx_ff, sqy_ff, sum_ff;
   logic [PROD_BITS-1:0]  px_ff, py_ff;
   logic [NUM_BITS-1:0]   nx_ff, ny_ff;

   always_comb begin
      ax_in = req.dir_x[COORD_BITS-1] ? COORD_BITS'(-req.dir_x) : COORD_BITS'(req.dir_x);
      ay_in = req.dir_y[COORD_BITS-1] ? COORD_BITS'(-req.dir_y) : COORD_BITS'(req.dir_y);
      side_in.neg_x = req.dir_x[COORD_BITS-1];
      side_in.neg_y = req.dir_y[COORD_BITS-1];
      side_in.zero  = (req.dir_x == '0) && (req.dir_y == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         len_ff    <= req.target_length;
         side_a_ff <= side_in;
         sqx_ff    <= SUM_BITS'(ax_ff) * SUM_BITS'(ax_ff);
         sqy_ff    <= SUM_BITS'(ay_ff) * SUM_BITS'(ay_ff);
         px_ff     <= PROD_BITS'(ax_ff) * PROD_BITS'(len_ff);
         py_ff     <= PROD_BITS'(ay_ff) * PROD_BITS'(len_ff);
         side_b_ff <= side_a_ff;
         sum_ff    <= sqx_ff + sqy_ff;
         nx_ff     <= NUM_BITS'(px_ff) * NUM_BITS'(px_ff);
         ny_ff     <= NUM_BITS'(py_ff) * NUM_BITS'(py_ff);
         side_c_ff <= side_b_ff;
      end
   end

   assign sum_sq = sum_ff;
   assign num_x  = nx_ff;
   assign num_y  = ny_ff;
   assign side   = side_c_ff;

endmodule

// ===== rtl/core/vrl_div.sv =====
module vrl_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [vrl_pkg::NUM_BITS-1:0]  num,
   input  logic [vrl_pkg::SUM_BITS-1:0]  den,
   output logic [vrl_pkg::QUO_BITS-1:0]  quo
);
   import vrl_pkg::*;

   // one quotient bit per stage, MSB first
   logic [NUM_BITS-1:0] rem_ff [0:QUO_BITS-2];
   logic [SUM_BITS-1:0] den_ff [0:QUO_BITS-2];
   logic [QUO_BITS-1:0] quo_ff [0:QUO_BITS-1];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [NUM_BITS-1:0] rem_cur, trial, rem_in;
      logic [SUM_BITS-1:0] den_cur;
      logic [QUO_BITS-1:0] quo_cur, quo_in;
      logic                take;

      if (k == 0) begin : g_first
         assign rem_cur = num;
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      assign trial  = NUM_BITS'(den_cur) << (QUO_BITS - 1 - k);
      assign take   = rem_cur >= trial;
      assign rem_in = take ? rem_cur - trial : rem_cur;
      assign quo_in = quo_cur | (take ? QUO_BITS'(1) << (QUO_BITS - 1 - k) : '0);

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < QUO_BITS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_cur;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

// ===== rtl/core/vrl_sqrt.sv =====
module vrl_sqrt (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [vrl_pkg::QUO_BITS-1:0]  rad,
   output logic [vrl_pkg::LEN_BITS-1:0]  root
);
   import vrl_pkg::*;

   localparam int TW = QUO_BITS + 1;

   logic [QUO_BITS-1:0] rem_ff  [0:LEN_BITS-2];
   logic [LEN_BITS-1:0] root_ff [0:LEN_BITS-1];

   for (genvar k = 0; k < LEN_BITS; k++) begin : g_stage
      localparam int B = LEN_BITS - 1 - k;
      logic [QUO_BITS-1:0] rem_cur, rem_in;
      logic [LEN_BITS-1:0] root_cur, root_in;
      logic [TW-1:0]       trial;
      logic                take;

      if (k == 0) begin : g_first
         assign rem_cur  = rad;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
      assign trial   = (TW'(root_cur) << (B + 1)) | (TW'(1) << (2 * B));
      assign take    = TW'(rem_cur) >= trial;
      assign rem_in  = take ? QUO_BITS'(TW'(rem_cur) - trial) : rem_cur;
      assign root_in = root_cur | (take ? LEN_BITS'(1) << B : '0);

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= root_in;
         end
      end

      if (k < LEN_BITS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign root = root_ff[LEN_BITS-1];

endmodule

// ===== rtl/core/vrl_checker.sv =====
module vrl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input vrl_pkg::req_type  req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vrl_pkg::rsp_type  rsp_payload
);
   import vrl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled rsp beat");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_vector |->
         rsp_payload.out_x == '0 && rsp_payload.out_y == '0)
      else $error("zero vector with nonzero components");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("req beat changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind vector_rescale_to_length vrl_checker u_vrl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
